// ===== sv/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths
  localparam int ADDR_W  = 11;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int CMD_W   = 3;
  localparam int COLOR_W = 4;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // Cell addresses used by the cursor logic and the sweeps
  localparam logic [ADDR_W-1:0] CELLS_A        = ADDR_W'(CELLS);
  localparam logic [ADDR_W-1:0] COLS_A         = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] UP_COPY_END    = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] DN_COPY_END    = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLUMNS - 1);

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TEXT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SCRL_DN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_CUR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  // Register index, taken from paddr bit 2 (registers at 0 and 4)
  localparam logic CFG_IDX_FG = 1'b0;
  localparam logic CFG_IDX_BG = 1'b1;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_NEXT_ROW,
    CUR_LAST_ROW,
    CUR_ZERO,
    CUR_SET
  } cur_op_t;

  typedef struct packed {
    logic    latch;          // item accepted: reset per-item flags
    logic    put;            // write character cell at cursor
    cur_op_t cur_op;
    logic    sw_load;        // load sweep counter
    logic    sw_load_top;    // ... with last cell instead of zero
    logic    sw_run;         // one sweep beat
    logic    sw_copy;        // sweep copies instead of fills
    logic    sw_down;        // sweep descends
    logic    sw_fill_reset;  // fill with reset cell value
    logic    rd_pos;         // read cell at input position
    logic    word_cap;       // capture read data
    logic    div_step;       // column extraction step
    logic    load_out;       // load result register
  } tcw_cmd_t;

  typedef struct packed {
    logic is_newline;
    logic cur_at_end;
    logic cur_last_row;
    logic pos_ok;
    logic rem_ge_cols;
    logic cnt_at_last;
    logic cnt_at_up_end;
    logic cnt_at_dn_end;
    logic cnt_at_zero;
  } tcw_stat_t;

endpackage

`default_nettype wire

// ===== sv/tcw_dp.sv =====
`default_nettype none

module tcw_dp import tcw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_cmd_t            cmd,
  input  logic [COLOR_W-1:0]  fg_color,
  input  logic [COLOR_W-1:0]  bg_color,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic [ADDR_W-1:0]   in_position,
  output tcw_stat_t           stat,
  output logic [ADDR_W-1:0]   out_cursor_pos,
  output logic                out_char_written,
  output logic [CELL_W-1:0]   out_cell_word
);

  logic [CELL_W-1:0] mem [CELLS];

  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] rem_r;
  logic              pend_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic              pend_copy_r;
  logic [CELL_W-1:0] pend_data_r;
  logic [CELL_W-1:0] rdata_r;
  logic              written_r;
  logic [CELL_W-1:0] word_r;
  logic [ADDR_W-1:0] out_cursor_r;
  logic              out_written_r;
  logic [CELL_W-1:0] out_word_r;

  logic [2*COLOR_W-1:0] attr;
  logic [CELL_W-1:0]    blank;
  logic [ADDR_W-1:0]    src;
  logic                 rd_en;
  logic [ADDR_W-1:0]    raddr;

  assign attr  = {bg_color, fg_color};
  assign blank = {attr, BLANK_CHAR};
  assign src   = cmd.sw_down ? (cnt_r - COLS_A) : (cnt_r + COLS_A);
  assign rd_en = cmd.rd_pos | (cmd.sw_run & cmd.sw_copy);
  assign raddr = cmd.rd_pos ? in_position : src;

  assign stat.is_newline    = (in_char_code == NEWLINE_CHAR);
  assign stat.cur_at_end    = (cursor_r == LAST_CELL);
  assign stat.cur_last_row  = (cursor_r >= LAST_ROW_START);
  assign stat.pos_ok        = (in_position < CELLS_A);
  assign stat.rem_ge_cols   = (rem_r >= COLS_A);
  assign stat.cnt_at_last   = (cnt_r == LAST_CELL);
  assign stat.cnt_at_up_end = (cnt_r == UP_COPY_END);
  assign stat.cnt_at_dn_end = (cnt_r == DN_COPY_END);
  assign stat.cnt_at_zero   = (cnt_r == '0);

  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    case (cmd.cur_op)
      CUR_HOLD: begin
      end
      CUR_ADV: begin
        cursor_nxt = cursor_r + 1'b1;
        col_nxt    = (col_r == LAST_COL) ? '0 : col_r + 1'b1;
      end
      CUR_NEXT_ROW: begin
        cursor_nxt = cursor_r - {{(ADDR_W-COL_W){1'b0}}, col_r} + COLS_A;
        col_nxt    = '0;
      end
      CUR_LAST_ROW: begin
        cursor_nxt = LAST_ROW_START;
        col_nxt    = '0;
      end
      CUR_ZERO: begin
        cursor_nxt = '0;
        col_nxt    = '0;
      end
      CUR_SET: begin
        cursor_nxt = in_position;
      end
      default: begin
      end
    endcase
    // remainder below one row width is the column
    if (cmd.div_step && !stat.rem_ge_cols) begin
      col_nxt = rem_r[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      pend_r   <= cmd.sw_run | cmd.put;
      if (cmd.sw_load) begin
        cnt_r <= cmd.sw_load_top ? LAST_CELL : '0;
      end else if (cmd.sw_run) begin
        cnt_r <= cmd.sw_down ? (cnt_r - 1'b1) : (cnt_r + 1'b1);
      end
    end
  end

  // write stage: one write per cycle; address and data are registered before the RAM write
  always_ff @(posedge clk) begin
    pend_addr_r <= cmd.put ? cursor_r : cnt_r;
    pend_copy_r <= cmd.sw_run & cmd.sw_copy;
    if (cmd.put) begin
      pend_data_r <= {attr, in_char_code};
    end else begin
      pend_data_r <= cmd.sw_fill_reset ? RESET_CELL : blank;
    end

    if (cmd.cur_op == CUR_SET) begin
      rem_r <= in_position;
    end else if (cmd.div_step && stat.rem_ge_cols) begin
      rem_r <= rem_r - COLS_A;
    end

    if (cmd.latch) begin
      written_r <= cmd.put;
      word_r    <= '0;
    end else if (cmd.word_cap) begin
      word_r <= rdata_r;
    end

    if (cmd.load_out) begin
      out_cursor_r  <= cursor_r;
      out_written_r <= written_r;
      out_word_r    <= word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      mem[pend_addr_r] <= pend_copy_r ? rdata_r : pend_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_cursor_pos   = out_cursor_r;
  assign out_char_written = out_written_r;
  assign out_cell_word    = out_word_r;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  input  tcw_stat_t        stat,
  output tcw_cmd_t         cmd
);

  typedef enum logic [10:0] {
    S_INIT     = 11'b000_0000_0001,
    S_DRAIN    = 11'b000_0000_0010,
    S_IDLE     = 11'b000_0000_0100,
    S_CLEAR    = 11'b000_0000_1000,
    S_UP_COPY  = 11'b000_0001_0000,
    S_UP_BLANK = 11'b000_0010_0000,
    S_DN_COPY  = 11'b000_0100_0000,
    S_DN_BLANK = 11'b000_1000_0000,
    S_RDWAIT   = 11'b001_0000_0000,
    S_DIV      = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.cur_op    = CUR_HOLD;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_INIT: begin
        cmd.sw_run        = 1'b1;
        cmd.sw_fill_reset = 1'b1;
        if (stat.cnt_at_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_FINISH;
          case (in_cmd)
            CMD_TEXT: begin
              if (stat.is_newline) begin
                if (stat.cur_last_row) begin
                  cmd.cur_op  = CUR_LAST_ROW;
                  cmd.sw_load = 1'b1;
                  state_nxt   = S_UP_COPY;
                end else begin
                  cmd.cur_op = CUR_NEXT_ROW;
                end
              end else begin
                cmd.put = 1'b1;
                if (stat.cur_at_end) begin
                  cmd.cur_op  = CUR_LAST_ROW;
                  cmd.sw_load = 1'b1;
                  state_nxt   = S_UP_COPY;
                end else begin
                  cmd.cur_op = CUR_ADV;
                end
              end
            end
            CMD_CLEAR: begin
              cmd.cur_op  = CUR_ZERO;
              cmd.sw_load = 1'b1;
              state_nxt   = S_CLEAR;
            end
            CMD_SCRL_DN: begin
              cmd.cur_op      = CUR_ZERO;
              cmd.sw_load     = 1'b1;
              cmd.sw_load_top = 1'b1;
              state_nxt       = S_DN_COPY;
            end
            CMD_SET_CUR: begin
              if (stat.pos_ok) begin
                cmd.cur_op = CUR_SET;
                state_nxt  = S_DIV;
              end
            end
            CMD_READ: begin
              if (stat.pos_ok) begin
                cmd.rd_pos = 1'b1;
                state_nxt  = S_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sw_run = 1'b1;
        if (stat.cnt_at_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_UP_COPY: begin
        cmd.sw_run  = 1'b1;
        cmd.sw_copy = 1'b1;
        if (stat.cnt_at_up_end) begin
          state_nxt = S_UP_BLANK;
        end
      end
      S_UP_BLANK: begin
        cmd.sw_run = 1'b1;
        if (stat.cnt_at_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_DN_COPY: begin
        cmd.sw_run  = 1'b1;
        cmd.sw_copy = 1'b1;
        cmd.sw_down = 1'b1;
        if (stat.cnt_at_dn_end) begin
          state_nxt = S_DN_BLANK;
        end
      end
      S_DN_BLANK: begin
        cmd.sw_run  = 1'b1;
        cmd.sw_down = 1'b1;
        if (stat.cnt_at_zero) begin
          state_nxt = S_FINISH;
        end
      end
      S_RDWAIT: begin
        cmd.word_cap = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (!stat.rem_ge_cols) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Text console writer: an 80x25 screen of 16-bit cells (attribute in the high
// byte, character in the low byte) plus a cursor.
// Input channel (in_valid/in_stall): one beat carries in_cmd, in_char_code and
// in_position. Result channel (out_valid/out_stall): one beat per command with
// the cursor after the command, the char-written flag and, for a cell read,
// the cell word. Colors are set through the APB port (fg at 0x0, bg at 0x4).
// One command is in flight at a time; in_stall is high while it runs.
// What each command does between accept and out_valid:
//   text byte / newline / set-cursor or read out of range / unused cmd: straight to the result
//   read cell: a registered read of the screen RAM
//   set cursor: column found by repeated subtraction of a row width
//   clear, scroll down, and any text byte that scrolls up: the screen RAM is
//   swept one cell per cycle.
// Plain text beats are taken one at a time; the next waits for the last to finish.
// Reset: after rst_n is released the RAM is filled with white-on-black spaces,
// one cell per cycle; in_stall stays high until the fill and the drain state
// are done. Config writes are taken during that time.
// A stalled result holds in the output register; a finished command waits for
// the register to free before the next beat is taken.
`default_nettype none

module text_console_writer import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [ADDR_W-1:0]  in_position,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  out_cursor_pos,
  output logic               out_char_written,
  output logic [CELL_W-1:0]  out_cell_word,
  // APB config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;
  logic               cfg_wr;
  tcw_cmd_t           cmd;
  tcw_stat_t          stat;

  // Config registers. Only paddr bit 2 selects; pready is tied high, so the
  // write lands at the access beat.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1])
        CFG_IDX_FG: fg_r <= pwdata[COLOR_W-1:0];
        CFG_IDX_BG: bg_r <= pwdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1])
      CFG_IDX_FG: prdata = {{(DATA_W-COLOR_W){1'b0}}, fg_r};
      CFG_IDX_BG: prdata = {{(DATA_W-COLOR_W){1'b0}}, bg_r};
      default:    prdata = '0;
    endcase
  end

  // Sequencer: decodes the command and steps through sweeps, reads and the
  // column search; owns the handshakes.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Screen RAM, cursor, sweep counter and result register.
  tcw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .fg_color         (fg_r),
    .bg_color         (bg_r),
    .in_char_code     (in_char_code),
    .in_position      (in_position),
    .stat             (stat),
    .out_cursor_pos   (out_cursor_pos),
    .out_char_written (out_char_written),
    .out_cell_word    (out_cell_word)
  );

endmodule

`default_nettype wire
